// ----- rtl/tfn_pkg.sv -----
package tfn_pkg;

   // Coordinate and result formats
   localparam int COORD_WIDTH = 16;
   localparam int OUT_WIDTH   = 16;

   // Derived datapath widths
   localparam int EDGE_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int LEN_W   = $clog2(CROSS_W + 1);
   localparam int NORM_W  = 16;
   localparam int SQ_W    = 2 * NORM_W;
   localparam int LEN2_W  = SQ_W + 2;
   localparam int RHS_SH  = 30;
   localparam int RHS_W   = SQ_W + RHS_SH;
   localparam int ACC_W   = LEN2_W + 34;
   localparam int Q_W     = 15;
   localparam int STEPS   = Q_W;

   // Squared length limit for a degenerate triangle, units of 2^-48
   localparam logic [LEN2_W-1:0] DEGEN_LIMIT = LEN2_W'(64'd281474976);
   localparam logic [Q_W-1:0]    ONE_Q14     = Q_W'(16384);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ax;
      logic signed [COORD_WIDTH-1:0] ay;
      logic signed [COORD_WIDTH-1:0] az;
      logic signed [COORD_WIDTH-1:0] bx;
      logic signed [COORD_WIDTH-1:0] by;
      logic signed [COORD_WIDTH-1:0] bz;
      logic signed [COORD_WIDTH-1:0] cx;
      logic signed [COORD_WIDTH-1:0] cy;
      logic signed [COORD_WIDTH-1:0] cz;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] nx;
      logic signed [OUT_WIDTH-1:0] ny;
      logic signed [OUT_WIDTH-1:0] nz;
   } rsp_type;

endpackage

// ----- rtl/triangle_face_normal.sv -----
// Triangle face normal: takes three Q4.12 vertices per transaction and returns the
// unit normal of the face in Q1.14, or (0,0,1) for a degenerate triangle. The block
// is a pipeline that accepts one transaction every clock unless stalled: seven
// stages of edge, cross product, normalising shift and squared length, then the
// 15 stages of the bit-by-bit search for each unit component, plus the output
// register. A stall on the result side freezes the whole pipeline, and the input
// stall follows it in the same cycle.
module triangle_face_normal
   import tfn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic adv;

   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   // advance the pipeline unless a finished result is being held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // stage 1: edges
   logic                     v1_ff;
   logic signed [EDGE_W-1:0] e1_ff [3];
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic signed [EDGE_W-1:0] e1_in [3];
   logic signed [EDGE_W-1:0] e2_in [3];

   always_comb begin
      e1_in[0] = EDGE_W'(req_data.bx) - EDGE_W'(req_data.ax);
      e1_in[1] = EDGE_W'(req_data.by) - EDGE_W'(req_data.ay);
      e1_in[2] = EDGE_W'(req_data.bz) - EDGE_W'(req_data.az);
      e2_in[0] = EDGE_W'(req_data.cx) - EDGE_W'(req_data.ax);
      e2_in[1] = EDGE_W'(req_data.cy) - EDGE_W'(req_data.ay);
      e2_in[2] = EDGE_W'(req_data.cz) - EDGE_W'(req_data.az);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (adv) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
      end
   end

   // stage 2: partial products of the cross product
   logic                     v2_ff;
   logic signed [PROD_W-1:0] prod_ff [6];
   logic signed [PROD_W-1:0] prod_in [6];

   always_comb begin
      prod_in[0] = PROD_W'(e1_ff[1]) * PROD_W'(e2_ff[2]);
      prod_in[1] = PROD_W'(e1_ff[2]) * PROD_W'(e2_ff[1]);
      prod_in[2] = PROD_W'(e1_ff[2]) * PROD_W'(e2_ff[0]);
      prod_in[3] = PROD_W'(e1_ff[0]) * PROD_W'(e2_ff[2]);
      prod_in[4] = PROD_W'(e1_ff[0]) * PROD_W'(e2_ff[1]);
      prod_in[5] = PROD_W'(e1_ff[1]) * PROD_W'(e2_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         prod_ff <= prod_in;
      end
   end

   // stage 3: cross product, split into sign and magnitude
   logic                      v3_ff;
   logic [CROSS_W-1:0]        mag_ff [3];
   logic [2:0]                neg3_ff;
   logic [CROSS_W-1:0]        mag_in [3];
   logic [2:0]                neg3_in;
   logic signed [CROSS_W-1:0] cr [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cr[i]      = CROSS_W'(prod_ff[2*i]) - CROSS_W'(prod_ff[2*i+1]);
         neg3_in[i] = cr[i][CROSS_W-1];
         mag_in[i]  = neg3_in[i] ? CROSS_W'(-cr[i]) : CROSS_W'(cr[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         mag_ff  <= mag_in;
         neg3_ff <= neg3_in;
      end
   end

   // stage 4: bit length of the largest magnitude
   logic               v4_ff;
   logic [CROSS_W-1:0] mag4_ff [3];
   logic [2:0]         neg4_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   len_in;
   logic [CROSS_W-1:0] mag_or;

   always_comb begin
      mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
      len_in = '0;
      for (int i = 0; i < CROSS_W; i++) begin
         if (mag_or[i]) begin
            len_in = LEN_W'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         mag4_ff <= mag_ff;
         neg4_ff <= neg3_ff;
         len_ff  <= len_in;
      end
   end

   // stage 5: shift the magnitudes down to 16 bits
   logic              v5_ff;
   logic [NORM_W-1:0] m_ff [3];
   logic [2:0]        neg5_ff;
   logic              small5_ff;
   logic [NORM_W-1:0] m_in [3];
   logic [LEN_W-1:0]  shamt;

   always_comb begin
      shamt = (len_ff > LEN_W'(NORM_W)) ? (len_ff - LEN_W'(NORM_W)) : '0;
      for (int i = 0; i < 3; i++) begin
         m_in[i] = NORM_W'(mag4_ff[i] >> shamt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv) begin
         m_ff      <= m_in;
         neg5_ff   <= neg4_ff;
         small5_ff <= (len_ff <= LEN_W'(NORM_W - 1));
      end
   end

   // stage 6: squares of the normalised components
   logic            v6_ff;
   logic [SQ_W-1:0] sq_ff [3];
   logic [2:0]      neg6_ff;
   logic            small6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SQ_W'(m_ff[i]) * SQ_W'(m_ff[i]);
         end
         neg6_ff   <= neg5_ff;
         small6_ff <= small5_ff;
      end
   end

   // stage 7 feeds search slot 0: squared length, degenerate test, seed values
   logic                    sv_ff    [STEPS+1];
   logic                    sdeg_ff  [STEPS+1];
   logic [2:0]              sneg_ff  [STEPS+1];
   logic [LEN2_W-1:0]       slen2_ff [STEPS+1];
   logic [RHS_W-1:0]        srhs_ff  [STEPS+1][3];
   logic signed [ACC_W-1:0] sacca_ff [STEPS+1][3];
   logic signed [ACC_W-1:0] saccb_ff [STEPS+1][3];
   logic [Q_W-1:0]          sq_q_ff  [STEPS+1][3];
   logic [LEN2_W-1:0]       len2_in;

   assign len2_in = LEN2_W'(sq_ff[0]) + LEN2_W'(sq_ff[1]) + LEN2_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= v6_ff;
      end
      if (adv) begin
         sdeg_ff[0]  <= small6_ff && (len2_in <= DEGEN_LIMIT);
         sneg_ff[0]  <= neg6_ff;
         slen2_ff[0] <= len2_in;
         for (int i = 0; i < 3; i++) begin
            srhs_ff[0][i]  <= RHS_W'(sq_ff[i]) << RHS_SH;
            // (2q-1)^2 * len2 and (2q-1) * len2 with q = 0
            sacca_ff[0][i] <= ACC_W'(len2_in);
            saccb_ff[0][i] <= -ACC_W'(len2_in);
            sq_q_ff[0][i]  <= '0;
         end
      end
   end

   // search stages: one result bit per stage, most significant first
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam int B = STEPS - k;

      logic signed [ACC_W-1:0] trial  [3];
      logic signed [ACC_W-1:0] rhs_s  [3];
      logic signed [ACC_W-1:0] len2_s;
      logic [Q_W-1:0]          t      [3];
      logic [2:0]              take;

      always_comb begin
         len2_s = ACC_W'(slen2_ff[k-1]);
         for (int i = 0; i < 3; i++) begin
            t[i]     = sq_q_ff[k-1][i] | (Q_W'(1) << B);
            trial[i] = sacca_ff[k-1][i] + (saccb_ff[k-1][i] <<< (B + 2))
                       + (len2_s <<< (2 * B + 2));
            rhs_s[i] = ACC_W'(srhs_ff[k-1][i]);
            take[i]  = (t[i] <= ONE_Q14) && (trial[i] <= rhs_s[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else if (adv) begin
            sv_ff[k] <= sv_ff[k-1];
         end
         if (adv) begin
            sdeg_ff[k]  <= sdeg_ff[k-1];
            sneg_ff[k]  <= sneg_ff[k-1];
            slen2_ff[k] <= slen2_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               srhs_ff[k][i] <= srhs_ff[k-1][i];
               if (take[i]) begin
                  sacca_ff[k][i] <= trial[i];
                  saccb_ff[k][i] <= saccb_ff[k-1][i] + (len2_s <<< (B + 1));
                  sq_q_ff[k][i]  <= t[i];
               end else begin
                  sacca_ff[k][i] <= sacca_ff[k-1][i];
                  saccb_ff[k][i] <= saccb_ff[k-1][i];
                  sq_q_ff[k][i]  <= sq_q_ff[k-1][i];
               end
            end
         end
      end
   end

   // output register: apply signs, or substitute (0,0,1) for a degenerate face
   rsp_type rsp_data_in;
   logic signed [OUT_WIDTH-1:0] comp [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         comp[i] = sneg_ff[STEPS][i] ? -OUT_WIDTH'(sq_q_ff[STEPS][i])
                                     : OUT_WIDTH'(sq_q_ff[STEPS][i]);
      end
      if (sdeg_ff[STEPS]) begin
         rsp_data_in.nx = '0;
         rsp_data_in.ny = '0;
         rsp_data_in.nz = OUT_WIDTH'(ONE_Q14);
      end else begin
         rsp_data_in.nx = comp[0];
         rsp_data_in.ny = comp[1];
         rsp_data_in.nz = comp[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sv_ff[STEPS];
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/tfn_checker.sv -----
module tfn_checker
   import tfn_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed");

   // hold a stalled input transaction
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled input transaction changed");

   // input stall only while a result is held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // pipeline empty after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // components stay within plus or minus one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.nx <= 16'sd16384 && rsp_data.nx >= -16'sd16384
                 && rsp_data.ny <= 16'sd16384 && rsp_data.ny >= -16'sd16384
                 && rsp_data.nz <= 16'sd16384 && rsp_data.nz >= -16'sd16384)
      else $error("normal component out of range");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);

// ----- dv/tb.sv -----
module tb;
   import tfn_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type expected_normals[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      stall_pct;
   int      hold_cycles;
   int      max_gap;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 60;

   triangle_face_normal DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // Clock generator; the reset pulse is driven by the main initial block
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Exact cross product, degenerate test, then bitwise search for each unit component
   function automatic rsp_type compute_normal(req_type t);
      longint            e1[3];
      longint            e2[3];
      longint            cr[3];
      longint unsigned   mg[3];
      longint unsigned   m[3];
      longint unsigned   len2;
      longint unsigned   rhs;
      longint unsigned   q;
      longint unsigned   cand;
      longint unsigned   d;
      logic              neg[3];
      logic [15:0]       comp[3];
      int                maxlen;
      int                shift;
      int                bl;
      rsp_type           r;
      e1[0] = longint'(t.bx) - longint'(t.ax);
      e1[1] = longint'(t.by) - longint'(t.ay);
      e1[2] = longint'(t.bz) - longint'(t.az);
      e2[0] = longint'(t.cx) - longint'(t.ax);
      e2[1] = longint'(t.cy) - longint'(t.ay);
      e2[2] = longint'(t.cz) - longint'(t.az);
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      maxlen = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = cr[i] < 0;
         mg[i]  = neg[i] ? unsigned'(-cr[i]) : unsigned'(cr[i]);
         bl     = $clog2(mg[i] + 1);
         if (bl > maxlen) maxlen = bl;
      end
      if (maxlen <= 15) begin
         len2 = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
         if (len2 <= 64'd281474976) begin
            r.nx = '0;
            r.ny = '0;
            r.nz = 16'sd16384;
            return r;
         end
      end
      shift = (maxlen > 16) ? maxlen - 16 : 0;
      for (int i = 0; i < 3; i++) m[i] = (mg[i] >> shift) & 64'hFFFF;
      len2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      for (int i = 0; i < 3; i++) begin
         rhs = (m[i] * m[i]) << 30;
         q   = 0;
         for (int b = 14; b >= 0; b--) begin
            cand = q | (64'd1 << b);
            d    = 2 * cand - 1;
            if (cand <= 16384 && d * d * len2 <= rhs) q = cand;
         end
         comp[i] = neg[i] ? 16'(-q) : 16'(q);
      end
      r.nx = comp[0];
      r.ny = comp[1];
      r.nz = comp[2];
      return r;
   endfunction

   // Offer one triangle, hold it until accepted, then record its normal
   task automatic send_triangle(req_type t);
      int gap;
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_normals.push_back(compute_normal(t));
      gap = 0;
      if (max_gap > 0) begin
         if ($urandom_range(0, 99) < 6) gap = $urandom_range(10, 40);
         else if ($urandom_range(0, 99) < 40) gap = $urandom_range(1, max_gap);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_type make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz);
      req_type t;
      t.ax = 16'(ax); t.ay = 16'(ay); t.az = 16'(az);
      t.bx = 16'(bx); t.by = 16'(by); t.bz = 16'(bz);
      t.cx = 16'(cx); t.cy = 16'(cy); t.cz = 16'(cz);
      return t;
   endfunction

   // Random triangle: full range, small, or near the degenerate boundary
   function automatic req_type random_tri();
      req_type      t;
      logic [159:0] raw;
      int           kind;
      int           spread;
      raw  = {$urandom, $urandom, $urandom, $urandom, $urandom};
      t    = raw[$bits(req_type)-1:0];
      kind = $urandom_range(0, 99);
      if (kind >= 50) begin
         spread = (kind < 70) ? 8 : (kind < 90) ? 200 : 2000;
         t.bx = t.ax + 16'($urandom_range(0, 2 * spread) - spread);
         t.by = t.ay + 16'($urandom_range(0, 2 * spread) - spread);
         t.bz = t.az + 16'($urandom_range(0, 2 * spread) - spread);
         t.cx = t.ax + 16'($urandom_range(0, 2 * spread) - spread);
         t.cy = t.ay + 16'($urandom_range(0, 2 * spread) - spread);
         t.cz = t.az + 16'($urandom_range(0, 2 * spread) - spread);
      end
      return t;
   endfunction

   task automatic wait_drained();
      while (expected_normals.size() != 0) @(posedge clock);
   endtask

   // Extremes, axis normals, degenerate and near-degenerate faces
   task automatic test_directed();
      max_gap = 0;
      send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_triangle(make_tri(100, -200, 300, 100, -200, 300, 100, -200, 300));
      send_triangle(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
      send_triangle(make_tri(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
      send_triangle(make_tri(0, 0, 0, 0, 4096, 0, 0, 0, 4096));
      send_triangle(make_tri(0, 0, 0, 0, 0, 4096, 4096, 0, 0));
      send_triangle(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                             -32768, 32767, -32768));
      send_triangle(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                             32767, -32768, 32767));
      send_triangle(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                             -32768, 32767, -32768));
      send_triangle(make_tri(0, 0, 0, 1000, 1000, 1000, 2000, 2000, 2000));
      send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
      send_triangle(make_tri(0, 0, 0, 128, 0, 0, 0, 128, 0));
      send_triangle(make_tri(0, 0, 0, 129, 0, 0, 0, 131, 0));
      send_triangle(make_tri(0, 0, 0, 16777, 0, 0, 0, 1, 0));
      send_triangle(make_tri(0, 0, 0, 16778, 0, 0, 0, 1, 0));
      send_triangle(make_tri(0, 0, 0, 100, 90, 0, 0, 0, 100));
      send_triangle(make_tri(-32768, 0, 0, 32767, 1, 0, -32768, 0, 1));
      send_triangle(make_tri(5, 7, 9, 32767, -32768, 12, -32768, 32767, -5));
      send_triangle(make_tri(0, 0, 0, 3, 5, 7, 11, 13, 17));
      send_triangle(make_tri(-1, -1, -1, 32767, -32768, 32767, -32768, 32767, 32767));
      req_valid <= 1'b0;
      wait_drained();
   endtask

   task automatic test_random(int count);
      max_gap = 4;
      stall_pct = 30;
      for (int i = 0; i < count; i++) begin
         send_triangle(random_tri());
         // stretches without any idling
         if (i % 300 == 150) begin max_gap = 0; stall_pct = 0; end
         if (i % 300 == 250) begin max_gap = 4; stall_pct = 30; end
      end
      req_valid <= 1'b0;
   endtask

   // Long receiver hold-off while items keep coming, then a drain and a further batch with gaps
   task automatic test_backpressure();
      max_gap = 0;
      hold_cycles = 300;
      for (int i = 0; i < 80; i++) send_triangle(random_tri());
      req_valid <= 1'b0;
      wait_drained();
      max_gap = 3;
      for (int i = 0; i < 40; i++) send_triangle(random_tri());
      req_valid <= 1'b0;
   endtask

   // Receiver stall pattern: short random stalls, occasional long runs, forced hold-off
   initial begin
      int stall_left;
      int free_left;
      stall_left = 0;
      free_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall   <= 1'b1;
            hold_cycles = hold_cycles - 1;
         end else if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left = stall_left - 1;
         end else if (free_left > 0 || stall_pct == 0) begin
            rsp_stall <= 1'b0;
            if (free_left > 0) free_left = free_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 99) < stall_pct)
               stall_left = ($urandom_range(0, 99) < 8) ? $urandom_range(15, 50)
                                                      : $urandom_range(1, 3);
            free_left = $urandom_range(0, 12);
         end
      end
   end

   // Compare each delivered normal with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_normals.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            error_count = error_count + 1;
         end else begin
            rsp_type exp_n;
            exp_n = expected_normals.pop_front();
            if (rsp_data.nx !== exp_n.nx) begin
               $display("%0t: nx expected %0d actual %0d", $time, exp_n.nx, rsp_data.nx);
               error_count = error_count + 1;
            end
            if (rsp_data.ny !== exp_n.ny) begin
               $display("%0t: ny expected %0d actual %0d", $time, exp_n.ny, rsp_data.ny);
               error_count = error_count + 1;
            end
            if (rsp_data.nz !== exp_n.nz) begin
               $display("%0t: nz expected %0d actual %0d", $time, exp_n.nz, rsp_data.nz);
               error_count = error_count + 1;
            end
         end
      end
   end

   // Cycle watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      stall_pct   = 0;
      hold_cycles = 0;
      max_gap     = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1300);
      test_backpressure();
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && expected_normals.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
